// ===== hdl/htbd_pkg.sv =====
// Shared types and constants for the Huffman tree bit decoder.
// Used by every module in hdl/; depends on nothing else.
package htbd_pkg;

   // Table geometry
   localparam int NODE_COUNT    = 512;
   localparam int NODE_IDX_W    = $clog2(NODE_COUNT);
   localparam int BITS_PER_BYTE = 8;

   // Fixed field widths
   localparam int CHILD_W  = 9;
   localparam int SYM_W    = 8;
   localparam int VBITS_W  = 4;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 8;

   // Request kinds (tuser)
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // One tree node as stored in the table
   typedef struct packed {
      logic               leaf;
      logic [SYM_W-1:0]   sym;
      logic [CHILD_W-1:0] left;
      logic [CHILD_W-1:0] right;
   } node_type;

   // Result of one tree step
   typedef struct packed {
      logic [CHILD_W-1:0] next;
      logic               miss;
   } step_type;

endpackage

// ===== hdl/htbd_node_ram.sv =====
// Node table memory: one write port, one read port with registered data.
// Depends on htbd_pkg.
module htbd_node_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [htbd_pkg::NODE_IDX_W-1:0] wr_addr,
   input  htbd_pkg::node_type             wr_data,
   input  logic                           rd_en,
   input  logic [htbd_pkg::NODE_IDX_W-1:0] rd_addr,
   output htbd_pkg::node_type             rd_data
);

   htbd_pkg::node_type mem [htbd_pkg::NODE_COUNT];
   htbd_pkg::node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/htbd_step.sv =====
// Tree step unit: picks the child for one code bit and flags a missing child.
// Depends on htbd_pkg.
module htbd_step (
   input  htbd_pkg::node_type node,
   input  htbd_pkg::node_type root,
   input  logic               code_bit,
   output htbd_pkg::step_type step
);

   htbd_pkg::node_type       eff;
   logic [htbd_pkg::CHILD_W-1:0] child;

   // A leaf restarts from the root before moving
   always_comb begin
      eff   = node.leaf ? root : node;
      child = code_bit ? eff.right : eff.left;
      step.next = child;
      step.miss = (child == '0) || (int'(child) >= htbd_pkg::NODE_COUNT);
   end

endmodule

// ===== hdl/huffman_tree_bit_decoder.sv =====
// Huffman tree bit decoder top level: request decode, sequencer, result register.
// Depends on htbd_pkg, htbd_node_ram and htbd_step.
//
// Load requests write one tree node, and req_tready stays high.
// A decode request walks the tree through one shared step unit and the node
// table's one read port. The input stays blocked while the sequencer runs:
// - it walks the code bits one at a time;
// - it latches each result;
// - it hands over each result that has a later one behind it;
// - it closes the byte, handing over the last result if the byte gave one.
// While rsp_tready is low and a result is offered, the sequencer waits.
// A result is held back until the next result or the end of the byte is known,
// so that rsp_tlast can be set correctly. The root node is mirrored in registers,
// so a leaf can restart from the root without a second table read.
// Table entries must be written before use.
module huffman_tree_bit_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // node_index[8:0], node_is_leaf[9], node_symbol[17:10], left_child[26:18],
   // right_child[35:27], code_byte[43:36], valid_bits[47:44]
   input  logic [htbd_pkg::REQ_W-1:0]  req_tdata,
   // operation[0]
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // symbol[7:0]
   output logic [htbd_pkg::RSP_W-1:0]  rsp_tdata,
   // decode_error[0]
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_STEP = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   // Request fields
   logic [htbd_pkg::CHILD_W-1:0] f_index;
   htbd_pkg::node_type           f_node;
   logic [htbd_pkg::SYM_W-1:0]   f_code;
   logic [htbd_pkg::VBITS_W-1:0] f_vbits;

   assign f_index      = req_tdata[8:0];
   assign f_node.leaf  = req_tdata[9];
   assign f_node.sym   = req_tdata[17:10];
   assign f_node.left  = req_tdata[26:18];
   assign f_node.right = req_tdata[35:27];
   assign f_code       = req_tdata[43:36];
   assign f_vbits      = req_tdata[47:44];

   // Control and payload registers
   logic [1:0]                   state_ff, state_in;
   logic [htbd_pkg::CHILD_W-1:0] cur_ff, cur_in;
   logic [htbd_pkg::SYM_W-1:0]   shift_ff, shift_in;
   logic [htbd_pkg::VBITS_W-1:0] left_ff, left_in;
   logic                         moved_ff, moved_in;
   logic                         have_ff, have_in;
   htbd_pkg::node_type           root_ff;
   logic [htbd_pkg::SYM_W-1:0]   sym_ff, sym_in;
   logic                         err_ff, err_in;
   logic                         last_ff, last_in;

   logic                         accept;
   logic                         wr_en, rd_en;
   logic [htbd_pkg::NODE_IDX_W-1:0] wr_addr, rd_addr;
   htbd_pkg::node_type           rd_node;
   htbd_pkg::step_type           step;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Load path
   assign wr_en   = accept && (req_tuser == htbd_pkg::OP_LOAD)
                    && (int'(f_index) < htbd_pkg::NODE_COUNT);
   assign wr_addr = htbd_pkg::NODE_IDX_W'(f_index);

   htbd_node_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (f_node),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_node)
   );

   htbd_step u_step (
      .node     (rd_node),
      .root     (root_ff),
      .code_bit (shift_ff[htbd_pkg::BITS_PER_BYTE-1]),
      .step     (step)
   );

   // Root mirror
   always_ff @(posedge clock) begin
      if (wr_en && (f_index == '0)) begin
         root_ff <= f_node;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      moved_in = moved_ff;
      have_in  = have_ff;
      sym_in   = sym_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      rd_en    = 1'b0;
      rd_addr  = htbd_pkg::NODE_IDX_W'(cur_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == htbd_pkg::OP_DECODE)) begin
               rd_en    = 1'b1;
               shift_in = f_code;
               left_in  = (int'(f_vbits) > htbd_pkg::BITS_PER_BYTE)
                          ? htbd_pkg::VBITS_W'(htbd_pkg::BITS_PER_BYTE) : f_vbits;
               moved_in = 1'b0;
               have_in  = 1'b0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (moved_ff && rd_node.leaf) begin
               if (have_ff) begin
                  // hand over the held result first; this leaf is taken on return
                  last_in  = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  // just arrived on a leaf: hold its symbol
                  sym_in   = rd_node.sym;
                  err_in   = 1'b0;
                  have_in  = 1'b1;
                  moved_in = 1'b0;
               end
            end else if (left_ff == '0) begin
               // byte done: the held result, if any, is the last one
               if (have_ff) begin
                  last_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (step.miss) begin
               if (have_ff) begin
                  last_in  = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  // missing child: error, back to root, drop the rest
                  cur_in   = '0;
                  left_in  = '0;
                  moved_in = 1'b0;
                  sym_in   = '0;
                  err_in   = 1'b1;
                  have_in  = 1'b1;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = htbd_pkg::NODE_IDX_W'(step.next);
               cur_in   = step.next;
               shift_in = {shift_ff[htbd_pkg::SYM_W-2:0], 1'b0};
               left_in  = left_ff - 1'b1;
               moved_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               have_in  = 1'b0;
               state_in = ST_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff   <= '0;
         left_ff  <= '0;
         moved_ff <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         left_ff  <= left_in;
         moved_ff <= moved_in;
         have_ff  <= have_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      sym_ff   <= sym_in;
      err_ff   <= err_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = sym_ff;
   assign rsp_tuser  = err_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== bench/tb_huffman_tree_bit_decoder.sv =====
// Self-checking bench for huffman_tree_bit_decoder: loads code trees, decodes
// bytes and checks every symbol against an in-bench tree walk model.
// Depends on htbd_pkg and the huffman_tree_bit_decoder RTL.
module tb_huffman_tree_bit_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 320;
   localparam int LONG_HOLD       = 300;

   // One request as the bench sees it, before packing
   typedef struct {
      logic                            kind;
      logic [htbd_pkg::NODE_IDX_W-1:0] node_index;
      logic                            node_is_leaf;
      logic [htbd_pkg::SYM_W-1:0]      node_symbol;
      logic [htbd_pkg::CHILD_W-1:0]    left_child;
      logic [htbd_pkg::CHILD_W-1:0]    right_child;
      logic [htbd_pkg::SYM_W-1:0]      code_byte;
      logic [htbd_pkg::VBITS_W-1:0]    valid_bits;
   } tree_request_type;

   // One expected symbol result
   typedef struct {
      logic [htbd_pkg::SYM_W-1:0] symbol;
      logic                       decode_error;
      logic                       last_of_run;
   } symbol_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [htbd_pkg::REQ_W-1:0] req_tdata = '0;
   logic                       req_tuser = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [htbd_pkg::RSP_W-1:0] rsp_tdata;
   logic                       rsp_tuser;
   logic                       rsp_tlast;

   // Model state: node table copy and the walk position
   htbd_pkg::node_type              tree_nodes [htbd_pkg::NODE_COUNT];
   logic [htbd_pkg::NODE_IDX_W-1:0] walk_node = '0;
   symbol_result_type               pending_symbols [$];

   // Stimulus bookkeeping: nodes written so far
   bit                    node_seen [htbd_pkg::NODE_COUNT];
   int                    written_nodes [$];

   int                    requests_sent = 0;
   int                    error_count = 0;
   bit                    steady_flow = 1'b0;
   int                    hold_cycles_req = 0;
   int                    sink_stall = 0;
   symbol_result_type     want;

   huffman_tree_bit_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly short, now and then long
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // Model of one accepted request: a load writes a node, a decode walks the tree
   function automatic void predict_request(tree_request_type rq);
      symbol_result_type               run [$];
      symbol_result_type               r;
      int                              nbits;
      logic [htbd_pkg::NODE_IDX_W-1:0] cur;
      logic [htbd_pkg::CHILD_W-1:0]    nxt;
      if (rq.kind == htbd_pkg::OP_LOAD) begin
         tree_nodes[rq.node_index] = '{leaf: rq.node_is_leaf, sym: rq.node_symbol,
                                       left: rq.left_child, right: rq.right_child};
         return;
      end
      nbits = (rq.valid_bits > htbd_pkg::BITS_PER_BYTE) ? htbd_pkg::BITS_PER_BYTE
                                                       : int'(rq.valid_bits);
      for (int i = 0; i < nbits; i++) begin
         // a leaf restarts from the root before the step
         cur = tree_nodes[walk_node].leaf ? '0 : walk_node;
         nxt = rq.code_byte[htbd_pkg::BITS_PER_BYTE-1-i] ? tree_nodes[cur].right
                                                        : tree_nodes[cur].left;
         if (nxt == '0) begin
            walk_node = '0;
            r = '{symbol: '0, decode_error: 1'b1, last_of_run: 1'b0};
            run = {run, r};
            break;
         end
         walk_node = nxt;
         if (tree_nodes[nxt].leaf) begin
            r = '{symbol: tree_nodes[nxt].sym, decode_error: 1'b0, last_of_run: 1'b0};
            run = {run, r};
         end
      end
      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[k]) pending_symbols = {pending_symbols, run[k]};
   endfunction

   // Drive one request, wait for the handshake, then update the model
   task automatic send_request(tree_request_type rq);
      int n;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= rq.kind;
      req_tdata  <= {rq.valid_bits, rq.code_byte, rq.right_child, rq.left_child,
                     rq.node_symbol, rq.node_is_leaf, rq.node_index};
      do @(posedge clock); while (!req_tready);
      predict_request(rq);
      requests_sent++;
      // optional idle stretch on the request side
      if (!steady_flow && $urandom_range(0, 2) == 0) begin
         n = gap_length();
         repeat (n) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
   endtask

   // Every field random; callers override what matters
   function automatic tree_request_type random_request();
      tree_request_type rq;
      rq.kind         = 1'($urandom_range(0, 1));
      rq.node_index   = htbd_pkg::NODE_IDX_W'($urandom_range(0, htbd_pkg::NODE_COUNT-1));
      rq.node_is_leaf = 1'($urandom_range(0, 1));
      rq.node_symbol  = htbd_pkg::SYM_W'($urandom_range(0, 255));
      rq.left_child   = htbd_pkg::CHILD_W'($urandom_range(0, htbd_pkg::NODE_COUNT-1));
      rq.right_child  = htbd_pkg::CHILD_W'($urandom_range(0, htbd_pkg::NODE_COUNT-1));
      rq.code_byte    = htbd_pkg::SYM_W'($urandom_range(0, 255));
      rq.valid_bits   = htbd_pkg::VBITS_W'($urandom_range(0, 15));
      return rq;
   endfunction

   task automatic load_node(int idx, bit leaf, int sym, int left, int right);
      tree_request_type rq;
      rq = random_request();
      rq.kind         = htbd_pkg::OP_LOAD;
      rq.node_index   = htbd_pkg::NODE_IDX_W'(idx);
      rq.node_is_leaf = leaf;
      rq.node_symbol  = htbd_pkg::SYM_W'(sym);
      rq.left_child   = htbd_pkg::CHILD_W'(left);
      rq.right_child  = htbd_pkg::CHILD_W'(right);
      send_request(rq);
      if (!node_seen[idx]) begin
         node_seen[idx] = 1'b1;
         written_nodes = {written_nodes, idx};
      end
   endtask

   task automatic decode_byte(int code, int nbits);
      tree_request_type rq;
      rq = random_request();
      rq.kind       = htbd_pkg::OP_DECODE;
      rq.code_byte  = htbd_pkg::SYM_W'(code);
      rq.valid_bits = htbd_pkg::VBITS_W'(nbits);
      send_request(rq);
   endtask

   // Child pointer that never leads the walk into an unwritten entry
   function automatic int any_written_child();
      if (written_nodes.size() == 0 || $urandom_range(0, 2) == 0) return 0;
      return written_nodes[$urandom_range(0, written_nodes.size()-1)];
   endfunction

   // Mostly full bytes, some final partial bytes, a few zero and oversized counts
   function automatic int random_valid_bits();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return htbd_pkg::BITS_PER_BYTE;
      if (pick < 92) return $urandom_range(1, 7);
      if (pick < 96) return 0;
      return $urandom_range(9, 15);
   endfunction

   // Bottom-up tree build: leaves first, root (entry 0) last
   task automatic build_tree(int leaf_count, bit broken);
      int pool [$];
      bit taken [int];
      int idx, a, b, k;
      for (int i = 0; i < leaf_count; i++) begin
         do idx = $urandom_range(1, htbd_pkg::NODE_COUNT-1); while (taken.exists(idx));
         taken[idx] = 1'b1;
         load_node(idx, 1'b1, $urandom_range(0, 255), any_written_child(),
                   any_written_child());
         pool = {pool, idx};
      end
      while (pool.size() > 1) begin
         k = $urandom_range(0, pool.size()-1);
         a = pool[k];
         pool.delete(k);
         k = $urandom_range(0, pool.size()-1);
         b = pool[k];
         pool.delete(k);
         if (pool.size() == 0) idx = 0;
         else begin
            do idx = $urandom_range(1, htbd_pkg::NODE_COUNT-1); while (taken.exists(idx));
            taken[idx] = 1'b1;
         end
         // broken trees lose a branch now and then
         if (broken && $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) a = 0;
            else b = 0;
         end
         load_node(idx, 1'b0, $urandom_range(0, 255), a, b);
         pool = {pool, idx};
      end
   endtask

   // Small fixed tree, all-zero and all-one bytes, partial final bytes
   task automatic test_basic_walk();
      load_node(1, 1'b1, 8'h00, 0, 0);
      load_node(3, 1'b1, 8'hFF, 0, 0);
      load_node(4, 1'b1, 8'hA5, 0, 0);
      load_node(2, 1'b0, 8'h00, 3, 4);
      load_node(0, 1'b0, 8'h00, 1, 2);
      decode_byte(8'h00, 8);
      decode_byte(8'hFF, 8);
      decode_byte(8'hB0, 3);
      decode_byte(8'h80, 1);
   endtask

   // Missing child deep in the tree and at the root
   task automatic test_missing_child();
      load_node(2, 1'b0, 8'h00, 3, 0);
      decode_byte(8'hC0, 8);
      load_node(0, 1'b0, 8'h00, 1, 0);
      decode_byte(8'h80, 8);
   endtask

   // Zero bit count and counts above a byte
   task automatic test_valid_bit_counts();
      decode_byte(8'h00, 0);
      decode_byte(8'h55, 15);
      decode_byte(8'h7F, 9);
   endtask

   // Root that is itself a leaf; all-ones node fields
   task automatic test_leaf_root();
      load_node(htbd_pkg::NODE_COUNT-1, 1'b1, 8'h81, htbd_pkg::NODE_COUNT-1,
                htbd_pkg::NODE_COUNT-1);
      load_node(0, 1'b1, 8'h3C, 1, htbd_pkg::NODE_COUNT-1);
      decode_byte(8'h5A, 8);
      decode_byte(8'hFF, 8);
      load_node(0, 1'b1, 8'h11, 0, htbd_pkg::NODE_COUNT-1);
      decode_byte(8'h80, 2);
      // restore a regular tree for the following tests
      load_node(2, 1'b0, 8'h00, 3, 4);
      load_node(0, 1'b0, 8'h00, 1, 2);
   endtask

   // Result side holds off while requests keep coming, so the input stalls
   task automatic test_result_backpressure();
      steady_flow = 1'b1;
      hold_cycles_req = LONG_HOLD;
      repeat (16) decode_byte($urandom_range(0, 1) ? 0 : int'($urandom_range(0, 255)), 8);
      steady_flow = 1'b0;
   endtask

   // Random trees (some broken), stray node writes, then decodes against them
   task automatic test_random_trees();
      int start;
      start = requests_sent;
      while (requests_sent - start < RANDOM_REQUESTS) begin
         steady_flow = ($urandom_range(0, 5) == 0);
         build_tree($urandom_range(2, 12), $urandom_range(0, 4) == 0);
         repeat ($urandom_range(0, 2))
            if ($urandom_range(0, 3) == 0)
               load_node($urandom_range(0, htbd_pkg::NODE_COUNT-1), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 255), any_written_child(), any_written_child());
         repeat ($urandom_range(4, 14)) decode_byte($urandom_range(0, 255), random_valid_bits());
      end
      steady_flow = 1'b0;
   endtask

   // Result side ready: random stalls, long hold on request from a test
   always @(negedge clock) begin
      if (hold_cycles_req != 0) begin
         sink_stall = hold_cycles_req;
         hold_cycles_req = 0;
      end else if (sink_stall == 0 && !steady_flow && $urandom_range(0, 3) == 0) begin
         sink_stall = gap_length();
      end
      if (sink_stall != 0) begin
         rsp_tready <= 1'b0;
         sink_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest expected symbol
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_symbols.size() == 0) begin
            $display("%0t: unexpected result, expected none, got symbol %h error %b last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_tdata !== want.symbol) begin
               $display("%0t: symbol mismatch, expected %h, got %h",
                        $time, want.symbol, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.decode_error) begin
               $display("%0t: decode_error mismatch, expected %b, got %b",
                        $time, want.decode_error, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.last_of_run) begin
               $display("%0t: last_of_run mismatch, expected %b, got %b",
                        $time, want.last_of_run, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Test sequence
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_walk();
      test_missing_child();
      test_valid_bit_counts();
      test_leaf_root();
      test_result_backpressure();
      test_random_trees();
      @(negedge clock);
      req_tvalid <= 1'b0;
      steady_flow = 1'b1;
      while (pending_symbols.size() != 0) @(posedge clock);
      // catch any stray results after the last expected one
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("%0t: timeout", $time);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
